[hw/rtl/lfs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lfs_pkg;

    localparam int HDR_LEN    = 6;
    localparam int HDR_CNT_W  = $clog2(HDR_LEN);
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef logic [1:0] status_t;

    localparam status_t ST_DATA      = 2'd0;
    localparam status_t ST_BAD_START = 2'd1;
    localparam status_t ST_TOO_BIG   = 2'd2;

    localparam logic CFG_START_WORD = 1'b0;
    localparam logic CFG_MAX_LEN    = 1'b1;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        first;
        logic        last;
        logic [31:0] number;
        status_t     status;
    } result_t;

    // one write into the result queue
    typedef struct packed {
        logic    push;
        logic    rewind;
        logic    commit;
        result_t entry;
    } push_t;

endpackage

`default_nettype wire

[hw/rtl/lfs_result_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module lfs_result_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lfs_pkg::push_t  wr,
    output logic                 full,
    output logic                 head_valid,
    output lfs_pkg::result_t     head,
    input  wire logic            pop
);
    import lfs_pkg::*;

    logic [FIFO_AW:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW:0] cm_ptr_reg, cm_ptr_next;
    logic [FIFO_AW:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0] wr_base;
    result_t          mem_reg [FIFO_DEPTH];

    // entries past the commit pointer are held back until the header checks out
    assign wr_base = wr.rewind ? cm_ptr_reg : wr_ptr_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        cm_ptr_next = cm_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr.push)
        begin
            wr_ptr_next = wr_base + (FIFO_AW + 1)'(1);
            if (wr.commit)
            begin
                cm_ptr_next = wr_base + (FIFO_AW + 1)'(1);
            end
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + (FIFO_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            cm_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            cm_ptr_reg <= cm_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            mem_reg[wr_base[FIFO_AW-1:0]] <= wr.entry;
        end
    end

    assign full = (wr_ptr_reg[FIFO_AW] != rd_ptr_reg[FIFO_AW])
               && (wr_ptr_reg[FIFO_AW-1:0] == rd_ptr_reg[FIFO_AW-1:0]);
    assign head_valid = (cm_ptr_reg != rd_ptr_reg);
    assign head       = mem_reg[rd_ptr_reg[FIFO_AW-1:0]];

endmodule

`default_nettype wire

[hw/rtl/length_prefixed_frame_splitter_top.sv]
// a payload byte is queued and committed as it is taken; header bytes are queued
// as they arrive and held until the sixth is taken, then offered one per cycle
// while out_ready is high, or replaced by an error item if the header is bad
// throughput: one input item per cycle while the eight-entry result queue has room
// reset (rst_n, async, active low): header phase, counters zero, queue empty
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_frame_splitter_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             frame_first,
    output logic             frame_last,
    output logic [31:0]      frame_number,
    output logic [1:0]       status,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);
    import lfs_pkg::*;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_HALT    = 2'd2;

    localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HDR_LEN - 1);

    logic [1:0]           phase_reg, phase_next;
    logic [HDR_CNT_W-1:0] hcnt_reg, hcnt_next;
    logic [31:0]          rem_reg, rem_next;
    logic [31:0]          fcnt_reg, fcnt_next;
    logic [15:0]          start_word_reg;
    logic [31:0]          max_len_reg;
    logic [7:0]           hdr_reg [HDR_LEN-1];

    logic        in_fire;
    logic        halted;
    logic        hdr_wr;
    logic [15:0] hdr_word;
    logic [31:0] hdr_len;
    logic [31:0] fnum_new;
    logic        q_full;
    logic        q_valid;
    result_t     q_head;
    push_t       push;

    assign halted    = (phase_reg != PH_HEADER) && (phase_reg != PH_PAYLOAD);
    assign in_ready  = halted || !q_full;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign hdr_word = {hdr_reg[1], hdr_reg[0]};
    assign hdr_len  = {data_byte, hdr_reg[4], hdr_reg[3], hdr_reg[2]};
    assign fnum_new = fcnt_reg + 32'd1;

    always_comb
    begin
        phase_next = phase_reg;
        hcnt_next  = hcnt_reg;
        rem_next   = rem_reg;
        fcnt_next  = fcnt_reg;
        hdr_wr     = 1'b0;
        push       = '0;
        if (in_fire)
        begin
            unique case (phase_reg)
                PH_PAYLOAD:
                begin
                    rem_next              = rem_reg - 32'd1;
                    push.push             = 1'b1;
                    push.commit           = 1'b1;
                    push.entry.out_byte   = data_byte;
                    push.entry.last       = (rem_reg == 32'd1);
                    push.entry.number     = fcnt_reg;
                    push.entry.status     = ST_DATA;
                    if (rem_reg == 32'd1)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_HEADER:
                begin
                    if (hcnt_reg != HDR_LAST)
                    begin
                        // queued but not yet visible on the output
                        hdr_wr              = 1'b1;
                        hcnt_next           = hcnt_reg + HDR_CNT_W'(1);
                        push.push           = 1'b1;
                        push.entry.out_byte = data_byte;
                        push.entry.first    = (hcnt_reg == '0);
                        push.entry.number   = fnum_new;
                        push.entry.status   = ST_DATA;
                    end
                    else
                    begin
                        hcnt_next   = '0;
                        push.push   = 1'b1;
                        push.commit = 1'b1;
                        if (hdr_word != start_word_reg)
                        begin
                            push.rewind       = 1'b1;
                            push.entry.number = fcnt_reg;
                            push.entry.status = ST_BAD_START;
                            phase_next        = PH_HALT;
                        end
                        else if (hdr_len > max_len_reg)
                        begin
                            push.rewind       = 1'b1;
                            push.entry.number = fcnt_reg;
                            push.entry.status = ST_TOO_BIG;
                            phase_next        = PH_HALT;
                        end
                        else
                        begin
                            push.entry.out_byte = data_byte;
                            push.entry.last     = (hdr_len == 32'd0);
                            push.entry.number   = fnum_new;
                            push.entry.status   = ST_DATA;
                            fcnt_next           = fnum_new;
                            if (hdr_len != 32'd0)
                            begin
                                rem_next   = hdr_len;
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                end
                default:
                begin
                    // halted: byte is dropped
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hcnt_reg  <= '0;
            rem_reg   <= '0;
            fcnt_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            hcnt_reg  <= hcnt_next;
            rem_reg   <= rem_next;
            fcnt_reg  <= fcnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_word_reg <= '0;
            max_len_reg    <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_START_WORD: start_word_reg <= cfg_data[15:0];
                CFG_MAX_LEN:    max_len_reg    <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_wr)
        begin
            hdr_reg[hcnt_reg] <= data_byte;
        end
    end

    lfs_result_fifo u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (push),
        .full       (q_full),
        .head_valid (q_valid),
        .head       (q_head),
        .pop        (out_valid && out_ready)
    );

    assign out_valid    = q_valid;
    assign out_byte     = q_head.out_byte;
    assign frame_first  = q_head.first;
    assign frame_last   = q_head.last;
    assign frame_number = q_head.number;
    assign status       = q_head.status;

endmodule

`default_nettype wire

[hw/rtl/lfs_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module lfs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [7:0]  data_byte,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  out_byte,
    input wire logic        frame_first,
    input wire logic        frame_last,
    input wire logic [31:0] frame_number,
    input wire logic [1:0]  status,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic        cfg_index,
    input wire logic [31:0] cfg_data
);
    import lfs_pkg::*;

    // an error item is the last thing the block ever sends
    a_error_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (status != ST_DATA) |=> !out_valid)
        else $error("item offered after an error item");

    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_DATA)
        |-> (out_byte == 8'd0) && !frame_first && !frame_last)
        else $error("error item carries frame data");

    a_first_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_first |-> (status == ST_DATA))
        else $error("frame start marked on an error item");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready
        |=> out_valid && $stable(out_byte) && $stable(frame_number) && $stable(status))
        else $error("stalled output item changed");

endmodule

bind length_prefixed_frame_splitter_top lfs_checker u_lfs_checker (.*);

`default_nettype wire

[bench/tb_length_prefixed_frame_splitter_top.sv]
`timescale 1ns / 1ps

module tb_length_prefixed_frame_splitter_top;
    import lfs_pkg::*;

    localparam int unsigned RUN_LIMIT     = 400_000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          INTRO_LEN     = 23;

    typedef enum logic [1:0] {SEEK_HEADER, IN_PAYLOAD, STOPPED} split_state_t;

    typedef struct {
        logic [7:0] data;
        bit         fixed;
        result_t    want;
    } intro_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        frame_first;
    logic        frame_last;
    logic [31:0] frame_number;
    logic [1:0]  status;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    // splitter state as the bench sees it
    split_state_t split_state = SEEK_HEADER;
    logic [7:0]   hdr_bytes [HDR_LEN];
    int           hdr_fill = 0;
    logic [31:0]  payload_left = '0;
    logic [31:0]  frames_seen = '0;
    logic [15:0]  sync_word = '0;
    logic [31:0]  len_cap = '1;

    result_t      frame_bytes_due [$];
    int unsigned  mismatches = 0;
    int unsigned  cycle_count = 0;
    int unsigned  stall_left = 0;
    bit           calm = 1'b0;

    // three frames after reset: length two, length zero, length three
    intro_row_t intro_rows [INTRO_LEN] = '{
        '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h02, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b1, {8'hFF, 1'b0, 1'b0, 32'd1, ST_DATA}},
        '{8'h00, 1'b1, {8'h00, 1'b0, 1'b1, 32'd1, ST_DATA}},
        '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h03, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h80, 1'b1, {8'h80, 1'b0, 1'b0, 32'd3, ST_DATA}},
        '{8'h7F, 1'b1, {8'h7F, 1'b0, 1'b0, 32'd3, ST_DATA}},
        '{8'h01, 1'b1, {8'h01, 1'b0, 1'b1, 32'd3, ST_DATA}}
    };

    length_prefixed_frame_splitter_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .frame_first  (frame_first),
        .frame_last   (frame_last),
        .frame_number (frame_number),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // output stalls come in bursts of random length, no new burst starts while calm
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 13);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    function automatic void split_byte(input logic [7:0] b, ref result_t fresh [$]);
        result_t     r;
        logic [15:0] word;
        logic [31:0] len;
        fresh = {};
        case (split_state)
            IN_PAYLOAD:
            begin
                payload_left = payload_left - 1;
                r.out_byte = b;
                r.first = 1'b0;
                r.last = (payload_left == 0);
                r.number = frames_seen;
                r.status = ST_DATA;
                fresh = {fresh, r};
                if (payload_left == 0)
                    split_state = SEEK_HEADER;
            end
            SEEK_HEADER:
            begin
                hdr_bytes[hdr_fill] = b;
                hdr_fill++;
                if (hdr_fill == HDR_LEN)
                begin
                    hdr_fill = 0;
                    word = {hdr_bytes[1], hdr_bytes[0]};
                    len = {hdr_bytes[5], hdr_bytes[4], hdr_bytes[3], hdr_bytes[2]};
                    if (word != sync_word || len > len_cap)
                    begin
                        // start word is checked ahead of the length
                        r = '0;
                        r.number = frames_seen;
                        r.status = (word != sync_word) ? ST_BAD_START : ST_TOO_BIG;
                        fresh = {fresh, r};
                        split_state = STOPPED;
                    end
                    else
                    begin
                        frames_seen = frames_seen + 1;
                        for (int i = 0; i < HDR_LEN; i++)
                        begin
                            r.out_byte = hdr_bytes[i];
                            r.first = (i == 0);
                            r.last = (i == HDR_LEN - 1) && (len == 0);
                            r.number = frames_seen;
                            r.status = ST_DATA;
                            fresh = {fresh, r};
                        end
                        if (len != 0)
                        begin
                            payload_left = len;
                            split_state = IN_PAYLOAD;
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void note_mismatch(input string what, input result_t want,
                                          input result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected byte %h first %b last %b frame %0d status %0d,",
                     $realtime, what, want.out_byte, want.first, want.last,
                     want.number, want.status,
                     " got byte %h first %b last %b frame %0d status %0d",
                     got.out_byte, got.first, got.last, got.number, got.status);
    endfunction

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {out_byte, frame_first, frame_last, frame_number, status};
            if (frame_bytes_due.size() == 0)
            begin
                note_mismatch("output with nothing due", '0, got);
            end
            else
            begin
                want = frame_bytes_due[0];
                frame_bytes_due.delete(0);
                if (got.out_byte !== want.out_byte || got.first !== want.first ||
                    got.last !== want.last || got.number !== want.number ||
                    got.status !== want.status)
                    note_mismatch("output mismatch", want, got);
            end
        end
    end

    task automatic feed_byte(input logic [7:0] b, input bit fixed, input result_t want);
        result_t fresh [$];
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        do @(posedge clk); while (!in_ready);
        split_byte(b, fresh);
        if (fixed)
            frame_bytes_due = {frame_bytes_due, want};
        else
            foreach (fresh[i]) frame_bytes_due = {frame_bytes_due, fresh[i]};
    endtask

    task automatic send_header(input logic [15:0] word, input logic [31:0] len);
        logic [47:0] hdr;
        hdr = {len, word};
        for (int i = 0; i < HDR_LEN; i++)
            feed_byte(hdr[8 * i +: 8], 1'b0, '0);
    endtask

    task automatic configure(input logic [15:0] word, input logic [31:0] cap);
        logic [15:0] junk;
        junk = 16'($urandom);
        // upper half of the start word write is don't-care
        cfg_valid <= 1'b1;
        cfg_index <= CFG_START_WORD;
        cfg_data <= {junk, word};
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_MAX_LEN;
        cfg_data <= cap;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sync_word = word;
        len_cap = cap;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (frame_bytes_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] word;
        logic [31:0] cap;
        logic [31:0] len;
        int unsigned maxlen;
        int unsigned sent;
        int unsigned pick;
        int unsigned ending;

        in_valid <= 1'b0;
        data_byte <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_START_WORD;
        cfg_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (intro_rows[i])
            feed_byte(intro_rows[i].data, intro_rows[i].fixed, intro_rows[i].want);
        settle();

        for (int ph = 0; ph < 6; ph++)
        begin
            calm = (ph == 5);
            word = 16'($urandom);
            case (ph)
                0:
                begin
                    word = 16'hFFFF;
                    cap = 32'hFFFF_FFFF;
                end
                1: cap = 32'd0;
                2: cap = $urandom_range(1, 24);
                3:
                begin
                    word = 16'h0000;
                    cap = $urandom;
                end
                4: cap = $urandom_range(40, 300);
                default: cap = $urandom_range(0, 40);
            endcase
            configure(word, cap);
            maxlen = (cap < 40) ? cap : 40;
            sent = 0;
            while (sent < 60)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    len = maxlen;
                else if (pick < 3)
                    len = 0;
                else
                    len = $urandom_range(0, (maxlen < 12) ? maxlen : 12);
                send_header(word, len);
                for (int unsigned i = 0; i < len; i++)
                    feed_byte(8'($urandom), 1'b0, '0);
                sent += HDR_LEN + len;
            end
            settle();
        end

        // the block stops for good on an error, so the run ends by trying for one
        word = 16'($urandom);
        cap = $urandom_range(0, 1000);
        configure(word, cap);
        ending = $urandom_range(0, 2);
        case (ending)
            0: send_header(word ^ 16'($urandom_range(1, 16'hFFFF)), $urandom_range(0, cap));
            1: send_header(word, $urandom_range(cap + 1, 32'hFFFF_FFFF));
            default:
                repeat (6) feed_byte(8'($urandom), 1'b0, '0);
        endcase
        // anything after the error is dropped
        repeat ($urandom_range(4, 12)) feed_byte(8'($urandom), 1'b0, '0);
        settle();

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/lfs_pkg.sv
hw/rtl/lfs_result_fifo.sv
hw/rtl/length_prefixed_frame_splitter_top.sv
hw/rtl/lfs_checker.sv
bench/tb_length_prefixed_frame_splitter_top.sv
